### sv/fdrw_pkg.sv
// ----------------------------------------------------------------------------
// fdrw_pkg: shared types and constants
// Widths, field codes and the per-cell control bundle of the dedup window.
// ----------------------------------------------------------------------------
package fdrw_pkg;

    localparam int DEPTH     = 32;                  // cells in the window
    localparam int KEY_WIDTH = 32;                  // id bits compared
    localparam int CNT_W     = $clog2(DEPTH + 1);   // held count width
    localparam int TDATA_W   = 80;                  // output tdata, byte padded

    // input kind codes
    localparam logic KIND_MSG  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // result kind codes
    localparam logic RES_MSG   = 1'b0;
    localparam logic RES_ENTRY = 1'b1;

    typedef enum logic
    {
        ST_RUN,
        ST_READ
    } state_t;

    // control broadcast to every cell
    typedef struct packed
    {
        logic clear;    // drop every entry
        logic insert;   // shift toward older slots, new id into slot 0
        logic evict;    // with insert: the tail entry falls out
        logic drain;    // shift toward slot 0 for readout
    } cell_ctrl_t;

endpackage

### sv/fdrw_cell.sv
// ----------------------------------------------------------------------------
// fdrw_cell: one slot of the window
// Holds one id and its valid flag, compares it with the incoming key and
// moves it to either neighbor under the shared control.
// ----------------------------------------------------------------------------
module fdrw_cell
    import fdrw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic [KEY_WIDTH-1:0] key,
    input  logic [KEY_WIDTH-1:0] up_id,      // from the newer neighbor
    input  logic                 up_valid,
    input  logic                 up_tail,
    input  logic [KEY_WIDTH-1:0] down_id,    // from the older neighbor
    input  logic                 down_valid,
    output logic [KEY_WIDTH-1:0] id,
    output logic                 valid,
    output logic                 match,
    output logic                 tail
);

    logic [KEY_WIDTH-1:0] id_reg;
    logic [KEY_WIDTH-1:0] id_next;
    logic                 valid_reg;
    logic                 valid_next;

    always_comb
    begin
        id_next    = id_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            id_next    = up_id;
            // the tail entry moving past the window edge is dropped
            valid_next = up_valid & ~(up_tail & ctrl.evict);
        end
        else if (ctrl.drain)
        begin
            id_next    = down_id;
            valid_next = down_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id    = id_reg;
    assign valid = valid_reg;
    assign match = valid_reg & (id_reg == key);
    assign tail  = valid_reg & ~down_valid;

endmodule

### sv/fifo_dedup_recent_window.sv
// ----------------------------------------------------------------------------
// fifo_dedup_recent_window: window of recent distinct ids
// Drops duplicates, evicts the oldest id beyond capacity, reads out on demand.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis: tuser is the kind (0 message, 1 readout),
//   tdata[31:0] the message id. Results leave on m_axis through one output
//   register, so a new item is taken only in a cycle where that register is
//   empty or its result leaves.
//   A message item gives one result in the cycle after acceptance; back to
//   back messages are taken one per cycle unless the output stalls. The id
//   is compared against every cell in parallel; a new id shifts the chain
//   one slot older and enters slot 0. A readout drains the chain toward
//   slot 0 and emits one entry per cycle unless the output stalls, newest
//   first, tlast on the final one; no new item is taken until the last
//   entry is emitted. An empty readout gives one result with entry_valid
//   low. When m_axis_tready is low a held result stays and s_axis_tready
//   drops. Reset empties the window and sets capacity to 32. A write on
//   capacity_we (only while idle) sets the capacity and empties the window.
// ----------------------------------------------------------------------------
module fifo_dedup_recent_window
    import fdrw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               capacity_we,
    input  logic [CNT_W-1:0]   capacity_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // [31:0] message_id
    input  logic               s_axis_tuser,   // [0] kind
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] hit, [1] evicted_valid, [33:2] evicted_id, [39:34] held_count,
    // [71:40] entry_id, [72] entry_valid, [79:73] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,   // [0] result_kind
    output logic               m_axis_tlast
);

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     eff_cap;
    logic [CNT_W-1:0]     held_reg;
    logic [CNT_W-1:0]     held_next;
    logic [CNT_W-1:0]     rd_count_reg;
    logic [CNT_W-1:0]     rd_count_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [TDATA_W-1:0]   out_data_reg;
    logic [TDATA_W-1:0]   out_data_next;
    logic                 out_kind_reg;
    logic                 out_kind_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    cell_ctrl_t           ctrl;
    logic [KEY_WIDTH-1:0] key;
    logic [KEY_WIDTH-1:0] cell_id    [DEPTH];
    logic                 cell_valid [DEPTH];
    logic                 cell_match [DEPTH];
    logic                 cell_tail  [DEPTH];

    logic                 slot_free;
    logic                 in_fire;
    logic                 hit;
    logic                 evict;
    logic [KEY_WIDTH-1:0] tail_id;

    assign key       = s_axis_tdata[KEY_WIDTH-1:0];
    assign slot_free = ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = (state_reg == ST_RUN) & slot_free;
    assign in_fire   = s_axis_tvalid & s_axis_tready;

    // clamp capacity into 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    // ---- row of cells --------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] up_id;
            logic                 up_valid;
            logic                 up_tail;
            logic [KEY_WIDTH-1:0] down_id;
            logic                 down_valid;

            if (g == 0)
            begin : g_head
                assign up_id    = key;
                assign up_valid = 1'b1;
                assign up_tail  = 1'b0;
            end
            else
            begin : g_body
                assign up_id    = cell_id[g-1];
                assign up_valid = cell_valid[g-1];
                assign up_tail  = cell_tail[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_end
                assign down_id    = '0;
                assign down_valid = 1'b0;
            end
            else
            begin : g_mid
                assign down_id    = cell_id[g+1];
                assign down_valid = cell_valid[g+1];
            end

            fdrw_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (key),
                .up_id      (up_id),
                .up_valid   (up_valid),
                .up_tail    (up_tail),
                .down_id    (down_id),
                .down_valid (down_valid),
                .id         (cell_id[g]),
                .valid      (cell_valid[g]),
                .match      (cell_match[g]),
                .tail       (cell_tail[g])
            );
        end
    endgenerate

    // gather hit and the oldest held id across the row
    always_comb
    begin
        hit     = 1'b0;
        tail_id = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit     = hit | cell_match[i];
            tail_id = tail_id | (cell_tail[i] ? cell_id[i] : '0);
        end
    end

    assign evict = ~hit & (held_reg >= eff_cap);

    // ---- control -------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        rd_count_next  = rd_count_reg;
        ctrl           = '0;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (capacity_we)
                begin
                    ctrl.clear = 1'b1;
                    held_next  = '0;
                end
                else if (in_fire)
                begin
                    if (s_axis_tuser == KIND_READ)
                    begin
                        if (held_reg == '0)
                        begin
                            // empty window: one result marked not valid
                            out_valid_next = 1'b1;
                            out_kind_next  = RES_ENTRY;
                            out_last_next  = 1'b1;
                            out_data_next  = '0;
                        end
                        else
                        begin
                            rd_count_next = held_reg;
                            state_next    = ST_READ;
                        end
                    end
                    else
                    begin
                        if (!hit)
                        begin
                            ctrl.insert = 1'b1;
                            ctrl.evict  = evict;
                            held_next   = evict ? held_reg : held_reg + CNT_W'(1);
                        end
                        out_valid_next        = 1'b1;
                        out_kind_next         = RES_MSG;
                        out_last_next         = 1'b1;
                        out_data_next         = '0;
                        out_data_next[0]      = hit;
                        out_data_next[1]      = evict;
                        out_data_next[33:2]   = evict ? tail_id : '0;
                        out_data_next[39:34]  = held_next;
                    end
                end
            end

            ST_READ:
            begin
                if (slot_free)
                begin
                    // emit slot 0 and pull the chain one slot newer
                    ctrl.drain            = 1'b1;
                    held_next             = held_reg - CNT_W'(1);
                    out_valid_next        = 1'b1;
                    out_kind_next         = RES_ENTRY;
                    out_last_next         = (held_reg == CNT_W'(1));
                    out_data_next         = '0;
                    out_data_next[39:34]  = rd_count_reg;
                    out_data_next[71:40]  = cell_id[0];
                    out_data_next[72]     = 1'b1;
                    if (held_reg == CNT_W'(1))
                    begin
                        state_next = ST_RUN;
                    end
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            cap_reg       <= CNT_W'(DEPTH);
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (capacity_we)
            begin
                cap_reg <= capacity_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_count_reg <= rd_count_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---- checks --------------------------------------------------------
    a_held_within_cap : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (held_reg <= eff_cap))
        else $error("held count above capacity");

    a_head_tracks_held : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cell_valid[0] == (held_reg != '0)))
        else $error("slot 0 valid disagrees with held count");

    a_hit_keeps_held : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser == KIND_MSG && hit && !capacity_we)
        |=> (held_reg == $past(held_reg)))
        else $error("hit changed held count");

    a_no_take_in_read : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !s_axis_tready)
        else $error("item taken during readout");

endmodule
